>>> rtl/pdss_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pdss_pkg
// Types and constants shared by the displacement speed statistics block.
// ----------------------------------------------------------------------------
package pdss_pkg;

    localparam int NUM_TIMES = 6;
    localparam logic [2:0] REG_LOWER = 3'd0;
    localparam logic [2:0] REG_UPPER = 3'd1;
    localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic               pair;
        logic               pv;
        logic signed [31:0] disp;
        logic signed [32:0] dt;
        logic               summary;
    } job_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PDIV,
        ST_PAIR,
        ST_MDIV,
        ST_SUM
    } st_t;

endpackage : pdss_pkg
`default_nettype wire

>>> rtl/pdss_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pdss_div
// Restoring serial divider, signed, truncating toward zero, one bit a cycle.
// ----------------------------------------------------------------------------
module pdss_div
    import pdss_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic signed [63:0] num,
    input  wire logic signed [63:0] den,
    output logic                    done,
    output logic signed [63:0]      quot
);

    logic [63:0] q_reg, q_next;
    logic [63:0] r_reg, r_next;
    logic [63:0] d_reg, d_next;
    logic        neg_reg, neg_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [64:0] trial;

    always_comb
    begin
        q_next = q_reg;
        r_next = r_reg;
        d_next = d_reg;
        neg_next = neg_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial = '0;
        if (start)
        begin
            q_next = num[63] ? 64'(-num) : 64'(num);
            d_next = den[63] ? 64'(-den) : 64'(den);
            neg_next = num[63] ^ den[63];
            r_next = '0;
            cnt_next = 7'd64;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            trial = {r_reg, q_reg[63]} - {1'b0, d_reg};
            if (!trial[64])
            begin
                r_next = trial[63:0];
                q_next = {q_reg[62:0], 1'b1};
            end
            else
            begin
                r_next = {r_reg[62:0], q_reg[63]};
                q_next = {q_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
        neg_reg <= neg_next;
    end

    assign done = done_reg;
    assign quot = neg_reg ? 64'(-q_reg) : q_reg;

endmodule : pdss_div
`default_nettype wire

>>> rtl/pdss_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pdss_front
// Accepts images, forms pair differences and queues jobs for the back end.
// ----------------------------------------------------------------------------
module pdss_front
    import pdss_pkg::*;
#(
    parameter int MAX_IMAGES = 6
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic signed [31:0] value,
    input  wire logic               vvalid,
    input  wire logic               last,
    input  wire logic               cfg_we,
    input  wire logic [2:0]         cfg_idx,
    input  wire logic [31:0]        cfg_data,
    output logic                    job_valid,
    input  wire logic               job_ready,
    output job_t                    job
);

    logic signed [31:0] times_reg [NUM_TIMES];
    logic signed [31:0] prev_reg;
    logic               prevv_reg;
    logic [2:0]         idx_reg;
    logic               fire, pop, is_last;
    logic signed [32:0] diff, tk, tp;
    job_t               ent;
    job_t               head_reg, tail_reg;
    logic [1:0]         fill_reg;

    assign in_ready = (fill_reg != 2'd2);
    assign job_valid = (fill_reg != 2'd0);
    assign job = head_reg;
    assign fire = in_valid && in_ready;
    assign pop = job_valid && job_ready;
    assign is_last = last || (idx_reg >= 3'(MAX_IMAGES - 1));

    always_comb
    begin
        tk = (idx_reg < 3'(NUM_TIMES)) ? 33'(times_reg[idx_reg]) : '0;
        tp = (idx_reg != 3'd0) ? 33'(times_reg[idx_reg - 3'd1]) : '0;
        diff = 33'(prev_reg) - 33'(value);
        ent.pair = (idx_reg != 3'd0);
        ent.pv = prevv_reg && vvalid;
        ent.disp = (diff > 33'(S32_MAX)) ? S32_MAX :
                   (diff < 33'(S32_MIN)) ? S32_MIN : diff[31:0];
        ent.dt = tk - tp;
        ent.summary = is_last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NUM_TIMES; k++)
            begin
                times_reg[k] <= 32'(k * 65536);
            end
            prev_reg <= '0;
            prevv_reg <= 1'b0;
            idx_reg <= '0;
            fill_reg <= '0;
        end
        else
        begin
            if (cfg_we && cfg_idx >= 3'd2)
            begin
                times_reg[cfg_idx - 3'd2] <= cfg_data;
            end
            if (fire && !pop)
            begin
                fill_reg <= fill_reg + 2'd1;
            end
            else if (pop && !fire)
            begin
                fill_reg <= fill_reg - 2'd1;
            end
            if (fire)
            begin
                if (is_last)
                begin
                    prev_reg <= '0;
                    prevv_reg <= 1'b0;
                    idx_reg <= '0;
                end
                else
                begin
                    prev_reg <= value;
                    prevv_reg <= vvalid;
                    idx_reg <= idx_reg + 3'd1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && (fill_reg == 2'd0 || (pop && fill_reg == 2'd1)))
        begin
            head_reg <= ent;
        end
        else if (pop)
        begin
            head_reg <= tail_reg;
        end
        if (fire && !pop && fill_reg == 2'd1)
        begin
            tail_reg <= ent;
        end
    end

endmodule : pdss_front
`default_nettype wire

>>> rtl/pdss_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pdss_back
// Computes speeds with a shared divider, keeps statistics and emits results.
// ----------------------------------------------------------------------------
module pdss_back
    import pdss_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               job_valid,
    output logic                    job_ready,
    input  job_t                    job,
    input  wire logic               cfg_we,
    input  wire logic [2:0]         cfg_idx,
    input  wire logic [31:0]        cfg_data,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [167:0]            out_data,
    output logic                    out_kind,
    output logic                    out_last
);

    st_t                st_reg, st_next;
    job_t               job_reg, job_next;
    logic signed [31:0] lo_reg, hi_reg;
    logic signed [34:0] sum_reg, sum_next;
    logic signed [31:0] mn_reg, mn_next, mx_reg, mx_next;
    logic [2:0]         cnt_reg, cnt_next;
    logic signed [31:0] spd_reg, spd_next;
    logic               dstart, ddone;
    logic signed [63:0] dnum, dden, dq;
    logic signed [31:0] sat;
    logic               qual;

    pdss_div u_div (
        .clk(clk), .rst_n(rst_n), .start(dstart),
        .num(dnum), .den(dden), .done(ddone), .quot(dq)
    );

    assign sat = (dq > 64'(S32_MAX)) ? S32_MAX :
                 (dq < 64'(S32_MIN)) ? S32_MIN : dq[31:0];
    assign qual = (job_reg.disp > lo_reg) && (job_reg.disp < hi_reg);

    always_comb
    begin
        st_next = st_reg;
        job_next = job_reg;
        sum_next = sum_reg;
        mn_next = mn_reg;
        mx_next = mx_reg;
        cnt_next = cnt_reg;
        spd_next = spd_reg;
        dstart = 1'b0;
        dnum = {{32{job_reg.disp[31]}}, job_reg.disp} <<< 16;
        dden = 64'(job_reg.dt);
        job_ready = 1'b0;
        out_valid = 1'b0;
        out_kind = 1'b0;
        out_last = 1'b0;
        out_data = '0;
        case (st_reg)
            ST_IDLE:
            begin
                job_ready = 1'b1;
                if (job_valid)
                begin
                    job_next = job;
                    if (!job.pair)
                    begin
                        st_next = job.summary ? ST_MDIV : ST_IDLE;
                    end
                    else if (!job.pv)
                    begin
                        spd_next = '0;
                        st_next = ST_PAIR;
                    end
                    else if (job.dt == '0)
                    begin
                        spd_next = (job.disp > 0) ? S32_MAX :
                                   (job.disp < 0) ? S32_MIN : '0;
                        st_next = ST_PAIR;
                    end
                    else
                    begin
                        st_next = ST_PDIV;
                    end
                    if (job.pair && job.pv && job.dt != '0)
                    begin
                        dstart = 1'b1;
                        dnum = {{32{job.disp[31]}}, job.disp} <<< 16;
                        dden = 64'(job.dt);
                    end
                end
            end
            ST_PDIV:
            begin
                if (ddone)
                begin
                    spd_next = sat;
                    st_next = ST_PAIR;
                end
            end
            ST_PAIR:
            begin
                out_valid = 1'b1;
                out_data[31:0] = job_reg.pv ? job_reg.disp : '0;
                out_data[63:32] = spd_reg;
                out_data[64] = job_reg.pv;
                if (out_ready)
                begin
                    if (job_reg.pv && qual)
                    begin
                        if (cnt_reg == 3'd0)
                        begin
                            mn_next = spd_reg;
                            mx_next = spd_reg;
                        end
                        else
                        begin
                            if (spd_reg < mn_reg) mn_next = spd_reg;
                            if (spd_reg > mx_reg) mx_next = spd_reg;
                        end
                        sum_next = sum_reg + 35'(spd_reg);
                        cnt_next = cnt_reg + 3'd1;
                    end
                    st_next = job_reg.summary ? ST_MDIV : ST_IDLE;
                end
            end
            ST_MDIV:
            begin
                if (cnt_reg == 3'd0)
                begin
                    st_next = ST_SUM;
                end
                else
                begin
                    dstart = 1'b1;
                    dnum = 64'(sum_reg);
                    dden = {61'd0, cnt_reg};
                    st_next = ST_PDIV;
                    job_next.summary = 1'b0;
                    job_next.pair = 1'b0;
                end
            end
            ST_SUM:
            begin
                out_valid = 1'b1;
                out_kind = 1'b1;
                out_last = 1'b1;
                if (cnt_reg != 3'd0)
                begin
                    out_data[96:65] = spd_reg;
                    out_data[128:97] = mn_reg;
                    out_data[160:129] = mx_reg;
                    out_data[161] = 1'b1;
                end
                if (out_ready)
                begin
                    sum_next = '0;
                    mn_next = '0;
                    mx_next = '0;
                    cnt_next = '0;
                    st_next = ST_IDLE;
                end
            end
            default:
            begin
                st_next = ST_IDLE;
            end
        endcase
        if (st_reg == ST_PDIV && ddone && !job_reg.pair)
        begin
            st_next = ST_SUM;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= ST_IDLE;
            lo_reg <= S32_MIN;
            hi_reg <= S32_MAX;
            sum_reg <= '0;
            mn_reg <= '0;
            mx_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            st_reg <= st_next;
            sum_reg <= sum_next;
            mn_reg <= mn_next;
            mx_reg <= mx_next;
            cnt_reg <= cnt_next;
            if (cfg_we && cfg_idx == REG_LOWER) lo_reg <= cfg_data;
            if (cfg_we && cfg_idx == REG_UPPER) hi_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg <= job_next;
        spd_reg <= spd_next;
    end

endmodule : pdss_back
`default_nettype wire

>>> rtl/pixel_displacement_speed_stats.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pixel_displacement_speed_stats
// Per-pixel displacement and speed between successive images, with summary.
// ----------------------------------------------------------------------------
// One beat on the slave side carries one image value of a pixel. Every image
// after the first gives a pair beat on the master side; the final image of a
// pixel also gives a summary beat with tlast set. tuser is the result kind.
// The front end forms the saturated displacement and the time difference and
// puts the job into a two-entry queue; the back end divides with a shared
// one-bit-a-cycle divider of 64 steps.
// A pair beat follows its image beat through the queue and the idle, divide and
// pair states; the back end takes a new job only when idle. A summary passes the
// mean, divide and summary states, and skips the divide if no pair qualified.
// A stalled master side holds the beat; the queue then fills and the slave
// side stalls. Reset restores the configuration registers to their defaults
// and clears pixel state. Configuration writes go through the plain write port;
// the user must make them only while idle, as the block does not enforce it.
// ----------------------------------------------------------------------------
module pixel_displacement_speed_stats
    import pdss_pkg::*;
#(
    parameter int MAX_IMAGES = 6
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [39:0]  s_tdata,   // image_value, value_valid
    input  wire logic         s_tlast,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [167:0]      m_tdata,   // disp, speed, pair_valid, mean, min, max, stats_valid
    output logic              m_tuser,   // result_kind
    output logic              m_tlast,
    input  wire logic         cfg_we,
    input  wire logic [2:0]   cfg_idx,
    input  wire logic [31:0]  cfg_data
);

    logic jv, jr;
    job_t jb;

    pdss_front #(.MAX_IMAGES(MAX_IMAGES)) u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(s_tvalid), .in_ready(s_tready),
        .value(s_tdata[31:0]), .vvalid(s_tdata[32]), .last(s_tlast),
        .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
        .job_valid(jv), .job_ready(jr), .job(jb)
    );

    pdss_back u_back (
        .clk(clk), .rst_n(rst_n), .job_valid(jv), .job_ready(jr), .job(jb),
        .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
        .out_valid(m_tvalid), .out_ready(m_tready), .out_data(m_tdata),
        .out_kind(m_tuser), .out_last(m_tlast)
    );

endmodule : pixel_displacement_speed_stats
`default_nettype wire

>>> rtl/pdss_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pdss_checker
// Port-level checks of the displacement speed statistics block.
// ----------------------------------------------------------------------------
module pdss_checker
(
    input wire logic         clk,
    input wire logic         rst_n,
    input wire logic         m_tvalid,
    input wire logic         m_tready,
    input wire logic [167:0] m_tdata,
    input wire logic         m_tuser,
    input wire logic         m_tlast
);

    a_last_is_summary: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tlast == m_tuser)) else $error("tlast without summary");

    a_pair_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser) |-> (m_tdata[167:65] == '0)) else $error("pair stats set");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("beat dropped");

endmodule : pdss_checker

bind pixel_displacement_speed_stats pdss_checker u_chk (
    .clk(clk), .rst_n(rst_n), .m_tvalid(m_tvalid), .m_tready(m_tready),
    .m_tdata(m_tdata), .m_tuser(m_tuser), .m_tlast(m_tlast)
);
`default_nettype wire
